// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared constants, codes and control types for the sorted priority queue
// used by spq_ctrl, spq_datapath and sorted_priority_queue_unit
package spq_pkg;

    localparam int DEPTH_DEF    = 128;
    localparam int PRI_BITS_DEF = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 8;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP_MIN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_MAX = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EXISTS  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_APPLY = 5'b00100,
        S_EVAL2 = 5'b01000,
        S_INS2  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                load;
        logic                eval;
        logic                insert;
        logic                remove;
        logic                dec;
        logic                capture;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              full;
        logic              found;
    } stat_t;

endpackage

// ===== rtl/sorted_priority_queue_unit.sv =====
// sorted_priority_queue_unit: top level of the sorted priority queue
// depends on spq_pkg, spq_ctrl and spq_datapath
//
// usage:
//   a request (mode, priority_req, key, sub_value) is taken at a rising edge
//   with start high and busy low. modes: insert, pop minimum, pop maximum,
//   peek minimum, update, exists.
//   each request gives one result (status, out_key, out_sub, present,
//   fill_count), shown for one cycle with strobe high; there is no
//   backpressure on the result side, the receiver must take it then.
// timing:
//   entries sit in a chain of cells that compare against the request in
//   parallel and all shift by one place together.
//   most requests pass through S_EVAL (compare) and S_APPLY (shift) before
//   strobe is raised; an update that finds its key goes on from its removal
//   shift in S_APPLY to S_EVAL2 (a second compare) and S_INS2 (an insertion
//   shift). busy drops as the result is registered, so the next request can
//   be taken in the cycle strobe is shown; no new request is taken while one
//   is still in flight.
// reset:
//   rst_n clears the entry count, the result strobe and the sequencer; cell
//   contents are left as they are and are never read above the count.
module sorted_priority_queue_unit #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int PRI_BITS = spq_pkg::PRI_BITS_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [spq_pkg::MODE_W-1:0]   mode,
    input  logic [PRI_BITS-1:0]          priority_req,
    input  logic [KEY_BITS-1:0]          key,
    input  logic [KEY_BITS-1:0]          sub_value,
    output logic                         strobe,
    output logic [spq_pkg::STATUS_W-1:0] status,
    output logic [KEY_BITS-1:0]          out_key,
    output logic [KEY_BITS-1:0]          out_sub,
    output logic                         present,
    output logic [spq_pkg::FILL_W-1:0]   fill_count
);

    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    spq_datapath #(
        .DEPTH    (DEPTH),
        .PRI_BITS (PRI_BITS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .priority_req (priority_req),
        .key          (key),
        .sub_value    (sub_value),
        .strobe       (strobe),
        .status       (status),
        .out_key      (out_key),
        .out_sub      (out_sub),
        .present      (present),
        .fill_count   (fill_count)
    );

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without a request in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == spq_pkg::ST_FULL) |-> fill_count == spq_pkg::FILL_W'(DEPTH))
        else $error("full status with room left");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == spq_pkg::ST_EMPTY) |-> (fill_count == '0 && out_key == '0))
        else $error("empty status with entries or data");

    a_present_exists: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && present) |-> status == spq_pkg::ST_OK)
        else $error("exists answer with error status");

endmodule

// ===== rtl/spq_ctrl.sv =====
// spq_ctrl: request sequencer for the sorted priority queue
// depends on spq_pkg; drives spq_datapath through cmd_t, reads stat_t
module spq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  spq_pkg::stat_t stat,
    output spq_pkg::cmd_t  cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = spq_pkg::ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = spq_pkg::S_EVAL;
                end
            end
            spq_pkg::S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = spq_pkg::S_APPLY;
            end
            spq_pkg::S_APPLY:
            begin
                state_next = spq_pkg::S_IDLE;
                unique case (stat.mode)
                    spq_pkg::MODE_INSERT:
                    begin
                        cmd.capture = 1'b1;
                        if (stat.full)
                        begin
                            cmd.status = spq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.insert = 1'b1;
                        end
                    end
                    spq_pkg::MODE_POP_MIN:
                    begin
                        cmd.capture = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.status = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.dec = 1'b1;
                        end
                    end
                    spq_pkg::MODE_POP_MAX:
                    begin
                        cmd.capture = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.status = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.remove = 1'b1;
                        end
                    end
                    spq_pkg::MODE_PEEK:
                    begin
                        cmd.capture = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.status = spq_pkg::ST_EMPTY;
                        end
                    end
                    spq_pkg::MODE_UPDATE:
                    begin
                        if (stat.found)
                        begin
                            cmd.remove = 1'b1;
                            state_next = spq_pkg::S_EVAL2;
                        end
                        else
                        begin
                            cmd.capture = 1'b1;
                            cmd.status  = spq_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        cmd.capture = 1'b1;
                    end
                endcase
            end
            spq_pkg::S_EVAL2:
            begin
                cmd.eval   = 1'b1;
                state_next = spq_pkg::S_INS2;
            end
            spq_pkg::S_INS2:
            begin
                cmd.insert  = 1'b1;
                cmd.capture = 1'b1;
                state_next  = spq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != spq_pkg::S_IDLE);

endmodule

// ===== rtl/spq_datapath.sv =====
// spq_datapath: sorted cell chain, request latch, match flags and result register
// depends on spq_pkg; commanded by spq_ctrl
module spq_datapath #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int PRI_BITS = spq_pkg::PRI_BITS_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spq_pkg::cmd_t                cmd,
    output spq_pkg::stat_t               stat,
    input  logic [spq_pkg::MODE_W-1:0]   mode,
    input  logic [PRI_BITS-1:0]          priority_req,
    input  logic [KEY_BITS-1:0]          key,
    input  logic [KEY_BITS-1:0]          sub_value,
    output logic                         strobe,
    output logic [spq_pkg::STATUS_W-1:0] status,
    output logic [KEY_BITS-1:0]          out_key,
    output logic [KEY_BITS-1:0]          out_sub,
    output logic                         present,
    output logic [spq_pkg::FILL_W-1:0]   fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [spq_pkg::MODE_W-1:0] mode_reg;
    logic [PRI_BITS-1:0]        pri_q_reg;
    logic [KEY_BITS-1:0]        key_q_reg;
    logic [KEY_BITS-1:0]        sub_q_reg;

    logic [PRI_BITS-1:0] pri_reg [DEPTH];
    logic [KEY_BITS-1:0] key_reg [DEPTH];
    logic [KEY_BITS-1:0] sub_reg [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] tail;
    logic [DEPTH-1:0] rem;
    logic [DEPTH-1:0] le_reg;
    logic [DEPTH-1:0] le_next;
    logic [DEPTH-1:0] km_reg;
    logic [DEPTH-1:0] km_next;
    logic [DEPTH-1:0] bm_reg;
    logic [DEPTH-1:0] bm_next;

    logic                         strobe_reg;
    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [KEY_BITS-1:0]          out_key_reg;
    logic [KEY_BITS-1:0]          out_sub_reg;
    logic                         present_reg;
    logic [spq_pkg::FILL_W-1:0]   fill_reg;

    logic [KEY_BITS-1:0] tail_key;
    logic [KEY_BITS-1:0] tail_sub;
    logic                is_pop_max;

    assign is_pop_max = (mode_reg == spq_pkg::MODE_POP_MAX);

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            pri_q_reg <= priority_req;
            key_q_reg <= key;
            sub_q_reg <= sub_value;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [PRI_BITS-1:0] pri_next;
            logic [KEY_BITS-1:0] key_next;
            logic [KEY_BITS-1:0] sub_next;

            assign valid[gi] = (count_reg > CNT_W'(gi));
            if (gi == DEPTH - 1)
            begin : g_last
                assign tail[gi] = valid[gi];
            end
            else
            begin : g_mid
                assign tail[gi] = valid[gi] && !valid[gi+1];
            end

            // removal point and everything above it
            assign rem[gi] = is_pop_max || ((km_reg << (DEPTH - 1 - gi)) != '0);

            assign le_next[gi] = !valid[gi] || (pri_reg[gi] <= pri_q_reg);
            assign km_next[gi] = valid[gi] && (key_reg[gi] == key_q_reg);
            assign bm_next[gi] = km_next[gi] && (sub_reg[gi] == sub_q_reg);

            always_comb
            begin
                pri_next = pri_reg[gi];
                key_next = key_reg[gi];
                sub_next = sub_reg[gi];
                if (cmd.insert)
                begin
                    if (gi > 0 && le_reg[(gi > 0) ? gi - 1 : 0])
                    begin
                        pri_next = pri_reg[(gi > 0) ? gi - 1 : 0];
                        key_next = key_reg[(gi > 0) ? gi - 1 : 0];
                        sub_next = sub_reg[(gi > 0) ? gi - 1 : 0];
                    end
                    else if (le_reg[gi])
                    begin
                        pri_next = pri_q_reg;
                        key_next = key_q_reg;
                        sub_next = sub_q_reg;
                    end
                end
                else if (cmd.remove && rem[gi] && gi < DEPTH - 1)
                begin
                    pri_next = pri_reg[(gi < DEPTH - 1) ? gi + 1 : gi];
                    key_next = key_reg[(gi < DEPTH - 1) ? gi + 1 : gi];
                    sub_next = sub_reg[(gi < DEPTH - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge clk)
            begin
                pri_reg[gi] <= pri_next;
                key_reg[gi] <= key_next;
                sub_reg[gi] <= sub_next;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            le_reg <= le_next;
            km_reg <= km_next;
            bm_reg <= bm_next;
        end
    end

    always_comb
    begin
        tail_key = '0;
        tail_sub = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_key = tail_key | (key_reg[i] & {KEY_BITS{tail[i]}});
            tail_sub = tail_sub | (sub_reg[i] & {KEY_BITS{tail[i]}});
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove || cmd.dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= cmd.capture;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            status_reg  <= cmd.status;
            fill_reg    <= spq_pkg::FILL_W'(count_next);
            out_key_reg <= '0;
            out_sub_reg <= '0;
            present_reg <= 1'b0;
            if (cmd.status == spq_pkg::ST_OK)
            begin
                if (mode_reg == spq_pkg::MODE_POP_MIN || mode_reg == spq_pkg::MODE_PEEK)
                begin
                    out_key_reg <= tail_key;
                    out_sub_reg <= tail_sub;
                end
                else if (is_pop_max)
                begin
                    out_key_reg <= key_reg[0];
                    out_sub_reg <= sub_reg[0];
                end
                else if (mode_reg == spq_pkg::MODE_EXISTS)
                begin
                    present_reg <= |bm_reg;
                end
            end
        end
    end

    assign stat.mode  = mode_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.found = |km_reg;

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign out_key    = out_key_reg;
    assign out_sub    = out_sub_reg;
    assign present    = present_reg;
    assign fill_count = fill_reg;

endmodule

// ===== dv/tb_sorted_priority_queue_unit.sv =====
// tb_sorted_priority_queue_unit: self-checking testbench for the sorted priority queue
// depends on spq_pkg and sorted_priority_queue_unit; checks every result against a
// behavioral copy of the queue, with a directed table followed by random requests
module tb_sorted_priority_queue_unit;

    localparam int QDEPTH = spq_pkg::DEPTH_DEF;

    typedef struct packed {
        logic [spq_pkg::MODE_W-1:0] mode;
        logic [15:0]                pri;
        logic [15:0]                key;
        logic [15:0]                sub;
    } request_t;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [15:0]                  key;
        logic [15:0]                  sub;
        logic                         present;
        logic [spq_pkg::FILL_W-1:0]   fill;
    } answer_t;

    typedef struct {
        request_t req;
        logic     typed;
        answer_t  ans;
    } row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [spq_pkg::MODE_W-1:0]   mode;
    logic [15:0]                  priority_req;
    logic [15:0]                  key;
    logic [15:0]                  sub_value;
    logic                         strobe;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [15:0]                  out_key;
    logic [15:0]                  out_sub;
    logic                         present;
    logic [spq_pkg::FILL_W-1:0]   fill_count;

    logic [15:0] q_pri [QDEPTH];
    logic [15:0] q_key [QDEPTH];
    logic [15:0] q_sub [QDEPTH];
    int          q_count;
    answer_t     pending_answers[$];
    int          errors;
    int          idle_pct;
    row_t        rows[$];

    sorted_priority_queue_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .priority_req(priority_req), .key(key), .sub_value(sub_value),
        .strobe(strobe), .status(status), .out_key(out_key), .out_sub(out_sub),
        .present(present), .fill_count(fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < q_count; i++)
        begin
            q_pri[i] = q_pri[i+1];
            q_key[i] = q_key[i+1];
            q_sub[i] = q_sub[i+1];
        end
        q_count--;
    endfunction

    function automatic void place_entry(logic [15:0] p, logic [15:0] k, logic [15:0] s);
        int pos;
        pos = q_count;
        for (int i = 0; i < q_count; i++)
            if (q_pri[i] <= p)
            begin
                pos = i;
                break;
            end
        for (int i = q_count; i > pos; i--)
        begin
            q_pri[i] = q_pri[i-1];
            q_key[i] = q_key[i-1];
            q_sub[i] = q_sub[i-1];
        end
        q_pri[pos] = p;
        q_key[pos] = k;
        q_sub[pos] = s;
        q_count++;
    endfunction

    function automatic answer_t queue_answer(request_t r);
        answer_t a;
        a = '0;
        case (r.mode)
            spq_pkg::MODE_INSERT:
                if (q_count >= QDEPTH) a.status = spq_pkg::ST_FULL;
                else place_entry(r.pri, r.key, r.sub);
            spq_pkg::MODE_POP_MIN, spq_pkg::MODE_PEEK:
                if (q_count == 0) a.status = spq_pkg::ST_EMPTY;
                else
                begin
                    a.key = q_key[q_count-1];
                    a.sub = q_sub[q_count-1];
                    if (r.mode == spq_pkg::MODE_POP_MIN) q_count--;
                end
            spq_pkg::MODE_POP_MAX:
                if (q_count == 0) a.status = spq_pkg::ST_EMPTY;
                else
                begin
                    a.key = q_key[0];
                    a.sub = q_sub[0];
                    drop_entry(0);
                end
            spq_pkg::MODE_UPDATE:
            begin
                a.status = spq_pkg::ST_NOT_FOUND;
                for (int i = 0; i < q_count; i++)
                    if (q_key[i] == r.key)
                    begin
                        drop_entry(i);
                        place_entry(r.pri, r.key, r.sub);
                        a.status = spq_pkg::ST_OK;
                        break;
                    end
            end
            spq_pkg::MODE_EXISTS:
                for (int i = 0; i < q_count; i++)
                    if (q_key[i] == r.key && q_sub[i] == r.sub)
                    begin
                        a.present = 1'b1;
                        break;
                    end
            default: ;
        endcase
        a.fill = q_count[spq_pkg::FILL_W-1:0];
        return a;
    endfunction

    // start stays high between back to back requests; it drops only while idling
    task automatic send_request(request_t r, logic typed, answer_t typed_ans);
        answer_t a;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        mode         <= r.mode;
        priority_req <= r.pri;
        key          <= r.key;
        sub_value    <= r.sub;
        @(posedge clk);
        while (busy) @(posedge clk);
        a = queue_answer(r);
        if (typed && a != typed_ans)
        begin
            $error("table row disagrees with queue behavior");
            errors++;
        end
        pending_answers.push_back(a);
    endtask

    always @(posedge clk)
        if (rst_n && strobe)
        begin
            answer_t e;
            if (pending_answers.size() == 0)
            begin
                $error("result with no request waiting");
                errors++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    errors++;
                end
                if (out_key !== e.key)
                begin
                    $error("out_key expected %0h actual %0h", e.key, out_key);
                    errors++;
                end
                if (out_sub !== e.sub)
                begin
                    $error("out_sub expected %0h actual %0h", e.sub, out_sub);
                    errors++;
                end
                if (present !== e.present)
                begin
                    $error("present expected %0d actual %0d", e.present, present);
                    errors++;
                end
                if (fill_count !== e.fill)
                begin
                    $error("fill_count expected %0d actual %0d", e.fill, fill_count);
                    errors++;
                end
            end
        end

    function automatic row_t mk(logic [spq_pkg::MODE_W-1:0] m, logic [15:0] p,
                                logic [15:0] k, logic [15:0] s, logic t, answer_t a);
        row_t r;
        r.req = '{m, p, k, s};
        r.typed = t;
        r.ans = a;
        return r;
    endfunction

    function automatic request_t rand_request(int phase_fill_bias);
        request_t r;
        int sel;
        r.pri = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        r.key = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
        r.sub = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        sel = $urandom_range(99);
        if (sel < phase_fill_bias) r.mode = spq_pkg::MODE_INSERT;
        else if (sel < phase_fill_bias + 8) r.mode = spq_pkg::MODE_POP_MIN;
        else if (sel < phase_fill_bias + 16) r.mode = spq_pkg::MODE_POP_MAX;
        else if (sel < phase_fill_bias + 22) r.mode = spq_pkg::MODE_PEEK;
        else if (sel < phase_fill_bias + 32) r.mode = spq_pkg::MODE_UPDATE;
        else if (sel < 97) r.mode = spq_pkg::MODE_EXISTS;
        else r.mode = spq_pkg::MODE_W'($urandom_range(6, 7));
        return r;
    endfunction

    initial
    begin
        int bias;
        errors       = 0;
        idle_pct     = 0;
        q_count      = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = spq_pkg::MODE_INSERT;
        priority_req = '0;
        key          = '0;
        sub_value    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty cases, extremes, every mode, unused modes
        rows.push_back(mk(spq_pkg::MODE_POP_MIN, 0, 0, 0, 1,
                          '{spq_pkg::ST_EMPTY, 0, 0, 0, 0}));
        rows.push_back(mk(spq_pkg::MODE_POP_MAX, 0, 0, 0, 1,
                          '{spq_pkg::ST_EMPTY, 0, 0, 0, 0}));
        rows.push_back(mk(spq_pkg::MODE_PEEK, 0, 0, 0, 1,
                          '{spq_pkg::ST_EMPTY, 0, 0, 0, 0}));
        rows.push_back(mk(spq_pkg::MODE_UPDATE, 5, 9, 9, 1,
                          '{spq_pkg::ST_NOT_FOUND, 0, 0, 0, 0}));
        rows.push_back(mk(spq_pkg::MODE_EXISTS, 0, 0, 0, 1,
                          '{spq_pkg::ST_OK, 0, 0, 0, 0}));
        rows.push_back(mk(3'd6, 16'hffff, 16'hffff, 16'hffff, 1,
                          '{spq_pkg::ST_OK, 0, 0, 0, 0}));
        rows.push_back(mk(3'd7, 0, 0, 0, 1, '{spq_pkg::ST_OK, 0, 0, 0, 0}));
        rows.push_back(mk(spq_pkg::MODE_INSERT, 16'hffff, 16'hffff, 16'hffff, 1,
                          '{spq_pkg::ST_OK, 0, 0, 0, 1}));
        rows.push_back(mk(spq_pkg::MODE_INSERT, 0, 0, 0, 1,
                          '{spq_pkg::ST_OK, 0, 0, 0, 2}));
        rows.push_back(mk(spq_pkg::MODE_INSERT, 7, 16'h1111, 1, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_INSERT, 7, 16'h2222, 2, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_EXISTS, 0, 16'hffff, 16'hffff, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_EXISTS, 0, 16'hffff, 0, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_PEEK, 0, 0, 0, 1,
                          '{spq_pkg::ST_OK, 0, 0, 0, 4}));
        rows.push_back(mk(spq_pkg::MODE_UPDATE, 16'h8000, 16'h1111, 16'h5555, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_UPDATE, 3, 16'h7777, 0, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_POP_MAX, 0, 0, 0, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_POP_MIN, 0, 0, 0, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_POP_MIN, 0, 0, 0, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_POP_MAX, 0, 0, 0, 0, '0));
        rows.push_back(mk(spq_pkg::MODE_POP_MIN, 0, 0, 0, 1,
                          '{spq_pkg::ST_EMPTY, 0, 0, 0, 0}));
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].ans);

        // fill to capacity and beyond for the full case
        for (int i = 0; i < QDEPTH + 3; i++)
            send_request('{spq_pkg::MODE_INSERT, 16'($urandom), 16'($urandom),
                           16'($urandom)}, 0, '0);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 77 : (phase == 3) ? 16 : 0;
            for (int n = 0; n < 420; n++)
            begin
                bias = (n % 200 < 100) ? 60 : 10;
                send_request(rand_request(bias), 0, '0);
            end
            start <= 1'b0;
            while (pending_answers.size() != 0) @(posedge clk);
        end

        repeat (20) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
